@@ rtl/core/idle_timeout_frame_collector_core_assert.svh @@
// ----------------------------------------------------------------------------
// idle timeout frame collector assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef IDLE_TIMEOUT_FRAME_COLLECTOR_CORE_ASSERT_SVH
`define IDLE_TIMEOUT_FRAME_COLLECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ITFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ITFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ITFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ITFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/itfc_pkg.sv @@
// ----------------------------------------------------------------------------
// itfc_pkg
// shared types and constants of the idle timeout frame collector
// ----------------------------------------------------------------------------
package itfc_pkg;

	// request kinds on the receive channel
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_TERM_CHAR     = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	// register reset values and byte codes
	localparam logic [7:0]  TERM_RESET    = 8'hff;
	localparam logic [15:0] TIMEOUT_RESET = 16'd25;
	localparam logic [7:0]  TERM_DISABLED = 8'hff;
	localparam logic [7:0]  ZERO_FILL     = 8'h7e;
	localparam logic [15:0] IDLE_MAX      = 16'hffff;

	// reason a frame was closed
	typedef enum logic [1:0] {
		CAUSE_TERM    = 2'd0,
		CAUSE_FULL    = 2'd1,
		CAUSE_TIMEOUT = 2'd2
	} cause_t;

	// control state
	typedef enum logic {
		ST_RUN  = 1'b0,
		ST_EMIT = 1'b1
	} st_t;

endpackage

@@ rtl/core/itfc_in_if.sv @@
// ----------------------------------------------------------------------------
// itfc_in_if
// receive channel: one received byte or one time tick per request
// ----------------------------------------------------------------------------
interface itfc_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

@@ rtl/core/itfc_out_if.sv @@
// ----------------------------------------------------------------------------
// itfc_out_if
// frame channel: one byte of a completed frame per request
// ----------------------------------------------------------------------------
interface itfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic [6:0] frame_length;
	logic [1:0] end_cause;
	logic       last;

	modport source (output valid, output data_byte, output byte_index,
		output frame_length, output end_cause, output last, input ready);
	modport sink (input valid, input data_byte, input byte_index,
		input frame_length, input end_cause, input last, output ready);
endinterface

@@ rtl/core/idle_timeout_frame_collector_core.sv @@
// Receive requests are taken one per cycle while no frame is being played out.
// A closing request moves the control state to emission; each frame byte is
// then read through the single frame store read port into the read stage and
// the output register, leaving one byte per cycle while the frame channel is
// ready. Receive ready is low while the store is read back, stalls included.
// Reset (arst_n, asynchronous) clears control state and registers; the frame
// store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// idle_timeout_frame_collector_core
// gathers received bytes into a frame store and plays out each closed frame
// ----------------------------------------------------------------------------
`include "idle_timeout_frame_collector_core_assert.svh"

module idle_timeout_frame_collector_core
	import itfc_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	itfc_in_if.sink     rx_in,
	itfc_out_if.source  frm_out
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	// configuration registers
	logic [7:0]  term_char_q;
	logic [15:0] timeout_q;

	// collector state
	st_t         state_q, state_d;
	logic        coll_q, coll_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0] idle_q, idle_d;
	logic [CW-1:0] emit_len_q, emit_len_d;
	cause_t      emit_cause_q, emit_cause_d;
	logic [CW-1:0] rd_ptr_q, rd_ptr_d;

	// store access
	logic [7:0]  mem [BUFFER_DEPTH];
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic        rd_en;
	logic        rx_ready;
	logic        rx_acc;
	logic        frame_end;
	logic [CW-1:0] cnt_inc;
	logic [15:0] idle_inc;
	logic [CW-1:0] ptr_inc;

	// read stage and output register
	logic        rd_valid_s1;
	logic [7:0]  rd_data_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [CW-1:0] rd_len_s1;
	cause_t      rd_cause_s1;
	logic        rd_last_s1;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic [AW-1:0] out_idx_q;
	logic [CW-1:0] out_len_q;
	cause_t      out_cause_q;
	logic        out_last_q;
	logic        out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_char_q <= TERM_RESET;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_TERM_CHAR:     term_char_q <= cfg_data[7:0];
				REG_TIMEOUT_TICKS: timeout_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	// requests are taken only while not playing out a frame
	assign rx_ready = (state_q == ST_RUN);
	assign rx_acc   = rx_in.valid && rx_ready;
	assign out_free = !out_valid_q || frm_out.ready;
	assign cnt_inc  = cnt_q + CW'(1);
	assign idle_inc = (idle_q == IDLE_MAX) ? IDLE_MAX : idle_q + 16'd1;
	assign ptr_inc  = rd_ptr_q + CW'(1);
	assign wr_addr  = coll_q ? cnt_q[AW-1:0] : '0;

	// next state and store control
	always_comb begin
		state_d      = state_q;
		coll_d       = coll_q;
		cnt_d        = cnt_q;
		idle_d       = idle_q;
		emit_len_d   = emit_len_q;
		emit_cause_d = emit_cause_q;
		rd_ptr_d     = rd_ptr_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		frame_end    = 1'b0;
		case (state_q)
			ST_RUN: begin
				if (rx_acc) begin
					if (rx_in.func == FUNC_BYTE) begin
						wr_en  = 1'b1;
						idle_d = '0;
						if (!coll_q) begin
							coll_d = 1'b1;
							cnt_d  = CW'(1);
						end else if (term_char_q != TERM_DISABLED &&
								rx_in.rx_byte == term_char_q) begin
							frame_end    = 1'b1;
							emit_len_d   = cnt_inc;
							emit_cause_d = CAUSE_TERM;
						end else if (cnt_inc >= DEPTH_C) begin
							frame_end    = 1'b1;
							emit_len_d   = cnt_inc;
							emit_cause_d = CAUSE_FULL;
						end else begin
							cnt_d = cnt_inc;
						end
					end else if (coll_q) begin
						idle_d = idle_inc;
						if (idle_inc >= timeout_q) begin
							frame_end    = 1'b1;
							emit_len_d   = cnt_q;
							emit_cause_d = CAUSE_TIMEOUT;
						end
					end
				end
				// close the frame and start reading it back
				if (frame_end) begin
					state_d  = ST_EMIT;
					coll_d   = 1'b0;
					cnt_d    = '0;
					idle_d   = '0;
					rd_ptr_d = '0;
				end
			end
			ST_EMIT: begin
				rd_en = !rd_valid_s1 || out_free;
				if (rd_en) begin
					rd_ptr_d = ptr_inc;
					if (ptr_inc == emit_len_q) begin
						state_d = ST_RUN;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			coll_q       <= 1'b0;
			cnt_q        <= '0;
			idle_q       <= '0;
			emit_len_q   <= '0;
			emit_cause_q <= CAUSE_TERM;
			rd_ptr_q     <= '0;
		end else begin
			state_q      <= state_d;
			coll_q       <= coll_d;
			cnt_q        <= cnt_d;
			idle_q       <= idle_d;
			emit_len_q   <= emit_len_d;
			emit_cause_q <= emit_cause_d;
			rd_ptr_q     <= rd_ptr_d;
		end
	end

	// frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_in.rx_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
		end
	end

	// read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (rd_en) begin
			rd_valid_s1 <= 1'b1;
		end else if (out_free) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1   <= rd_ptr_q[AW-1:0];
			rd_len_s1   <= emit_len_q;
			rd_cause_s1 <= emit_cause_q;
			rd_last_s1  <= (ptr_inc == emit_len_q);
		end
	end

	// output register, zero bytes replaced on a timeout frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && rd_valid_s1) begin
			out_data_q  <= (rd_cause_s1 == CAUSE_TIMEOUT && rd_data_s1 == 8'h00) ?
				ZERO_FILL : rd_data_s1;
			out_idx_q   <= rd_idx_s1;
			out_len_q   <= rd_len_s1;
			out_cause_q <= rd_cause_s1;
			out_last_q  <= rd_last_s1;
		end
	end

	assign rx_in.ready          = rx_ready;
	assign frm_out.valid        = out_valid_q;
	assign frm_out.data_byte    = out_data_q;
	assign frm_out.byte_index   = 6'(out_idx_q);
	assign frm_out.frame_length = 7'(out_len_q);
	assign frm_out.end_cause    = out_cause_q;
	assign frm_out.last         = out_last_q;

	// checks
	`ITFC_ASSERT_IMPLY(a_last_pos, clk, arst_n, out_valid_q && out_last_q,
		CW'(out_idx_q) + CW'(1) == out_len_q)
	`ITFC_ASSERT_NEXT(a_end_emit, clk, arst_n, frame_end,
		state_q == ST_EMIT && rd_ptr_q == '0 && !coll_q)
	`ITFC_ASSERT_IMPLY(a_rd_range, clk, arst_n, rd_en, rd_ptr_q < emit_len_q)
	`ITFC_ASSERT_NEXT(a_s1_hold, clk, arst_n, rd_valid_s1 && !out_free, rd_valid_s1)
	`ITFC_ASSERT_IMPLY(a_cnt_range, clk, arst_n, coll_q,
		cnt_q != '0 && cnt_q < DEPTH_C)

endmodule
